// ===== sv/flr_pkg.sv =====
package flr_pkg;

	// Parser phase of the frame receiver
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY,
		PH_TERM
	} phase_t;

	// Result kinds on the output channel
	typedef enum logic [2:0] {
		KIND_PAYLOAD,
		KIND_TX,
		KIND_COMPLETE,
		KIND_CORRUPT,
		KIND_ACK,
		KIND_NACK,
		KIND_DROPPED
	} kind_t;

	// Framing characters
	localparam logic [7:0] CH_START  = 8'h2A; // '*'
	localparam logic [7:0] CH_END    = 8'h23; // '#'
	localparam logic [7:0] CH_HEADER = 8'h7E; // '~'
	localparam logic [7:0] CH_DATA   = 8'h3E; // '>'
	localparam logic [7:0] CH_ACK    = 8'h3C; // '<'
	localparam logic [7:0] CH_NACK   = 8'h3F; // '?'
	localparam logic [7:0] CH_EOF    = 8'h40; // '@'
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'

	// Length of the acknowledge frame we transmit
	localparam int unsigned ACK_LEN = 5;
	localparam logic [2:0] ACK_LAST = 3'(ACK_LEN - 1);

	// Byte of the acknowledge frame "*<00#" at a given position
	function automatic logic [7:0] ack_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = CH_START;
			3'd1: b = CH_ACK;
			3'd2: b = CH_ZERO;
			3'd3: b = CH_ZERO;
			default: b = CH_END;
		endcase
		return b;
	endfunction

	// Decode one hex digit: {bad, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else begin
			r = {1'b1, 4'h0};
		end
		return r;
	endfunction

endpackage

// ===== sv/framed_link_receiver_with_ack.sv =====
// Framed link receiver: takes one link byte per cycle on rx_byte and parses frames
// '*', type, two hex length digits, body, '#'. Data frames ('>') pass their body out
// as payload items and add their length to the received count; header frames ('~')
// load the expected total from their decimal body and clear the count; both answer
// with the five-item acknowledge burst "*<00#" on the output. EOF frames ('@') report
// complete or corrupt together with the received count, and peer ACK/NACK frames and
// bad terminators are reported as single items. A byte is held in the one-byte input register
// and parsed from there, so the input runs at one byte per cycle while the output keeps up; an
// acknowledge burst holds the result register until its last item is taken. Bytes that cause
// no item keep flowing during a burst; the first byte that causes an item waits in the
// one-byte input register and stalls the input until the burst's last item is taken.
// last_of_run marks the final item caused by an input byte. The header total and the
// count are COUNT_WIDTH bits wide; message_length shows the low 32 bits of the count.
module framed_link_receiver_with_ack #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	input  logic                 res_ready,
	output flr_pkg::kind_t       out_kind,
	output logic [7:0]           out_byte,
	output logic [31:0]          message_length,
	output logic                 last_of_run
);
	import flr_pkg::*;

	localparam int WIDE = COUNT_WIDTH + 4;

	// Input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;

	// Parser state
	phase_t                 phase_q, phase_d;
	logic [7:0]             frame_kind_q, frame_kind_d;
	logic [7:0]             body_length_q, body_length_d;
	logic [7:0]             bytes_left_q, bytes_left_d;
	logic                   hex_fault_q, hex_fault_d;
	logic                   digit_fault_q, digit_fault_d;
	logic [COUNT_WIDTH-1:0] pending_q, pending_d;
	logic [COUNT_WIDTH-1:0] expected_q, expected_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;

	// Result register
	logic                   res_valid_q;
	logic                   res_burst_q;
	kind_t                  res_kind_q;
	logic [7:0]             res_byte_q;
	logic [31:0]            res_len_q;
	logic [2:0]             res_idx_q;

	// Result produced by the byte being parsed
	logic                   prod_any;
	logic                   prod_burst;
	kind_t                  prod_kind;
	logic [7:0]             prod_byte;
	logic [31:0]            prod_len;

	logic                   res_last;
	logic                   res_take;
	logic                   parse_fire;
	logic [4:0]             hex_dec;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [WIDE-1:0]        pend_wide;
	logic [WIDE-1:0]        pend_next;
	logic                   pend_ovf;
	logic                   lo_fault;
	logic [7:0]             lo_length;
	logic [7:0]             left_dec;

	// Output view of the result register
	assign res_last       = !res_burst_q || (res_idx_q == ACK_LAST);
	assign res_valid      = res_valid_q;
	assign out_kind       = res_burst_q ? KIND_TX : res_kind_q;
	assign out_byte       = res_burst_q ? ack_byte(res_idx_q) : res_byte_q;
	assign message_length = res_len_q;
	assign last_of_run    = res_last;

	// Result register can take a new item when empty or finishing now
	assign res_take   = !res_valid_q || (res_ready && res_last);
	assign parse_fire = valid_s1 && (res_take || !prod_any);
	assign rx_ready   = !valid_s1 || parse_fire;

	// Digit decode and decimal accumulate (x10 as two shifts)
	assign hex_dec   = hex_decode(byte_s1);
	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit     = 4'(byte_s1 - CH_ZERO);
	assign pend_wide = WIDE'(pending_q);
	assign pend_next = (pend_wide << 3) + (pend_wide << 1) + WIDE'(digit);
	assign pend_ovf  = |pend_next[WIDE-1:COUNT_WIDTH];
	assign lo_fault  = hex_fault_q | hex_dec[4];
	assign lo_length = lo_fault ? 8'h00 : (body_length_q | {4'h0, hex_dec[3:0]});
	assign left_dec  = bytes_left_q - 8'd1;

	// Next state and produced result
	always_comb begin
		phase_d       = phase_q;
		frame_kind_d  = frame_kind_q;
		body_length_d = body_length_q;
		bytes_left_d  = bytes_left_q;
		hex_fault_d   = hex_fault_q;
		digit_fault_d = digit_fault_q;
		pending_d     = pending_q;
		expected_d    = expected_q;
		count_d       = count_q;
		prod_any      = 1'b0;
		prod_burst    = 1'b0;
		prod_kind     = KIND_PAYLOAD;
		prod_byte     = 8'h00;
		prod_len      = 32'h0;
		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == CH_START) begin
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				frame_kind_d  = byte_s1;
				hex_fault_d   = 1'b0;
				digit_fault_d = 1'b0;
				pending_d     = '0;
				body_length_d = 8'h00;
				phase_d       = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				body_length_d = {hex_dec[3:0], 4'h0};
				hex_fault_d   = hex_fault_q | hex_dec[4];
				phase_d       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				hex_fault_d   = lo_fault;
				body_length_d = lo_length;
				bytes_left_d  = lo_length;
				phase_d       = (lo_length == 8'h00) ? PH_TERM : PH_BODY;
			end
			PH_BODY: begin
				if (frame_kind_q == CH_DATA) begin
					prod_any  = 1'b1;
					prod_kind = KIND_PAYLOAD;
					prod_byte = byte_s1;
				end else if (frame_kind_q == CH_HEADER) begin
					if (!is_digit) begin
						digit_fault_d = 1'b1;
					end else if (!digit_fault_q) begin
						if (pend_ovf) begin
							digit_fault_d = 1'b1;
						end else begin
							pending_d = pend_next[COUNT_WIDTH-1:0];
						end
					end
				end
				bytes_left_d = left_dec;
				if (left_dec == 8'h00) begin
					phase_d = PH_TERM;
				end
			end
			default: begin
				// Terminator; unused codes behave the same
				phase_d = PH_IDLE;
				if (byte_s1 != CH_END) begin
					prod_any  = 1'b1;
					prod_kind = KIND_DROPPED;
				end else if (frame_kind_q == CH_HEADER) begin
					expected_d = digit_fault_q ? '0 : pending_q;
					count_d    = '0;
					prod_any   = 1'b1;
					prod_burst = 1'b1;
					prod_kind  = KIND_TX;
				end else if (frame_kind_q == CH_DATA) begin
					count_d    = count_q + COUNT_WIDTH'(body_length_q);
					prod_any   = 1'b1;
					prod_burst = 1'b1;
					prod_kind  = KIND_TX;
				end else if (frame_kind_q == CH_EOF) begin
					prod_any  = 1'b1;
					prod_kind = (expected_q == count_q) ? KIND_COMPLETE : KIND_CORRUPT;
					prod_len  = 32'(count_q);
				end else if (frame_kind_q == CH_ACK) begin
					prod_any  = 1'b1;
					prod_kind = KIND_ACK;
				end else if (frame_kind_q == CH_NACK) begin
					prod_any  = 1'b1;
					prod_kind = KIND_NACK;
				end
			end
		endcase
	end

	// Hold the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Advance the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			frame_kind_q  <= 8'h00;
			body_length_q <= 8'h00;
			bytes_left_q  <= 8'h00;
			hex_fault_q   <= 1'b0;
			digit_fault_q <= 1'b0;
			pending_q     <= '0;
			expected_q    <= '0;
			count_q       <= '0;
		end else if (parse_fire) begin
			phase_q       <= phase_d;
			frame_kind_q  <= frame_kind_d;
			body_length_q <= body_length_d;
			bytes_left_q  <= bytes_left_d;
			hex_fault_q   <= hex_fault_d;
			digit_fault_q <= digit_fault_d;
			pending_q     <= pending_d;
			expected_q    <= expected_d;
			count_q       <= count_d;
		end
	end

	// Load a new result or step through the acknowledge burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_burst_q <= 1'b0;
			res_idx_q   <= 3'd0;
		end else if (parse_fire && prod_any) begin
			res_valid_q <= 1'b1;
			res_burst_q <= prod_burst;
			res_idx_q   <= 3'd0;
		end else if (res_valid_q && res_ready) begin
			if (res_last) begin
				res_valid_q <= 1'b0;
			end else begin
				res_idx_q <= res_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (parse_fire && prod_any) begin
			res_kind_q <= prod_kind;
			res_byte_q <= prod_byte;
			res_len_q  <= prod_len;
		end
	end

`ifndef SYNTH
	// A burst taken before its last item keeps the output valid
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last_of_run |=> res_valid)
		else $error("acknowledge burst cut short");

	// Burst position stays inside the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_burst_q |-> res_idx_q <= ACK_LAST)
		else $error("burst index out of range");

	// Count is shown only with complete or corrupt reports
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && message_length != 32'h0 |->
		out_kind == KIND_COMPLETE || out_kind == KIND_CORRUPT)
		else $error("count shown on wrong kind");

	// Last body byte moves the parser to the terminator
	assert property (@(posedge clk) disable iff (!arst_n)
		parse_fire && phase_q == PH_BODY && bytes_left_q == 8'd1 |=> phase_q == PH_TERM)
		else $error("body end missed");

	// A new result is loaded only into a free slot
	assert property (@(posedge clk) disable iff (!arst_n)
		parse_fire && prod_any |-> !res_valid_q || (res_ready && res_last))
		else $error("result overwritten");
`endif

endmodule

// ===== dv/tb_framed_link_receiver_with_ack.sv =====
`timescale 1ns / 100ps

module tb_framed_link_receiver_with_ack;
	import flr_pkg::*;

	localparam int COUNT_W = 32;

	// One expected output item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] len;
		logic        last;
	} link_result_t;

	// One slot of the rx byte stream; a drain slot holds the sender until the output is empty
	typedef struct packed {
		logic       drain;
		logic [7:0] data;
	} rx_slot_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        res_valid;
	logic        res_ready = 1'b0;
	kind_t       out_kind;
	logic [7:0]  out_byte;
	logic [31:0] message_length;
	logic        last_of_run;

	rx_slot_t     rx_stream[$];
	logic [7:0]   frame_body[$];
	link_result_t link_results_due[$];

	int unsigned stream_len = 0;
	int unsigned bytes_taken = 0;
	int unsigned failures = 0;
	bit          rx_taken = 1'b0;
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;
	bit          hold_off = 1'b0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;

	// Receiver state as the parser sees it
	phase_t             link_phase = PH_IDLE;
	logic [7:0]         frame_type = 8'h00;
	logic [7:0]         body_len = 8'h00;
	logic [7:0]         body_left = 8'h00;
	bit                 len_bad = 1'b0;
	bit                 total_bad = 1'b0;
	logic [COUNT_W-1:0] total_acc = '0;
	logic [COUNT_W-1:0] want_total = '0;
	logic [COUNT_W-1:0] got_count = '0;

	framed_link_receiver_with_ack DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_ready       (rx_ready),
		.rx_byte        (rx_byte),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.out_kind       (out_kind),
		.out_byte       (out_byte),
		.message_length (message_length),
		.last_of_run    (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic note_failure(input string what);
		failures++;
		if (failures <= 100)
			$display("%0t ns: %s", $time, what);
	endtask

	function automatic int hex_digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return c - 8'h30;
		if (c >= 8'h41 && c <= 8'h46)
			return c - 8'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66)
			return c - 8'h61 + 10;
		return -1;
	endfunction

	task automatic push_result(input kind_t k, input logic [7:0] d, input logic [31:0] l,
			input logic t);
		link_result_t r;
		r.kind = k;
		r.data = d;
		r.len = l;
		r.last = t;
		link_results_due.push_back(r);
	endtask

	// Advance the parser by one link byte and queue the items it causes
	task automatic predict_link_byte(input logic [7:0] b);
		int dv;
		logic [63:0] wide;
		case (link_phase)
			PH_IDLE: begin
				if (b == CH_START)
					link_phase = PH_TYPE;
			end
			PH_TYPE: begin
				frame_type = b;
				len_bad = 1'b0;
				total_bad = 1'b0;
				total_acc = '0;
				body_len = 8'h00;
				link_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				dv = hex_digit_value(b);
				if (dv < 0) begin
					len_bad = 1'b1;
					body_len = 8'h00;
				end else begin
					body_len = 8'(dv << 4);
				end
				link_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				dv = hex_digit_value(b);
				if (dv < 0)
					len_bad = 1'b1;
				else
					body_len = body_len | 8'(dv);
				if (len_bad)
					body_len = 8'h00;
				body_left = body_len;
				link_phase = (body_left == 0) ? PH_TERM : PH_BODY;
			end
			PH_BODY: begin
				if (frame_type == CH_DATA) begin
					push_result(KIND_PAYLOAD, b, 32'd0, 1'b1);
				end else if (frame_type == CH_HEADER) begin
					// accumulate decimal total; any bad digit or overflow sticks
					if (b >= CH_ZERO && b <= CH_NINE) begin
						if (!total_bad) begin
							wide = 64'(total_acc) * 64'd10 + 64'(b - CH_ZERO);
							if ((wide >> COUNT_W) != 0)
								total_bad = 1'b1;
							else
								total_acc = wide[COUNT_W-1:0];
						end
					end else begin
						total_bad = 1'b1;
					end
				end
				body_left = body_left - 8'd1;
				if (body_left == 0)
					link_phase = PH_TERM;
			end
			default: begin
				link_phase = PH_IDLE;
				if (b != CH_END) begin
					push_result(KIND_DROPPED, 8'h00, 32'd0, 1'b1);
				end else if (frame_type == CH_HEADER || frame_type == CH_DATA) begin
					if (frame_type == CH_HEADER) begin
						want_total = total_bad ? '0 : total_acc;
						got_count = '0;
					end else begin
						got_count = got_count + COUNT_W'(body_len);
					end
					push_result(KIND_TX, CH_START, 32'd0, 1'b0);
					push_result(KIND_TX, CH_ACK, 32'd0, 1'b0);
					push_result(KIND_TX, CH_ZERO, 32'd0, 1'b0);
					push_result(KIND_TX, CH_ZERO, 32'd0, 1'b0);
					push_result(KIND_TX, CH_END, 32'd0, 1'b1);
				end else if (frame_type == CH_EOF) begin
					push_result((want_total == got_count) ? KIND_COMPLETE : KIND_CORRUPT,
						8'h00, got_count[31:0], 1'b1);
				end else if (frame_type == CH_ACK) begin
					push_result(KIND_ACK, 8'h00, 32'd0, 1'b1);
				end else if (frame_type == CH_NACK) begin
					push_result(KIND_NACK, 8'h00, 32'd0, 1'b1);
				end
			end
		endcase
	endtask

	// Mostly no gap or a short one, now and then a long one
	function automatic int unsigned idle_len(input bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------- stimulus building ----------------

	task automatic push_byte(input logic [7:0] b);
		rx_slot_t s;
		s.drain = 1'b0;
		s.data = b;
		rx_stream.push_back(s);
		stream_len++;
	endtask

	task automatic push_drain();
		rx_slot_t s;
		s.drain = 1'b1;
		s.data = 8'h00;
		rx_stream.push_back(s);
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10)
			return CH_ZERO + 8'(v);
		return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	// Non-hex byte, often one right next to a hex range
	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		case ($urandom_range(0, 11))
			0: c = 8'h2F;
			1: c = 8'h3A;
			2: c = 8'h40;
			3: c = 8'h47;
			4: c = 8'h60;
			5: c = 8'h67;
			default: begin
				do
					c = 8'($urandom_range(0, 255));
				while (hex_digit_value(c) >= 0);
			end
		endcase
		return c;
	endfunction

	function automatic logic [7:0] bad_term();
		logic [7:0] c;
		if ($urandom_range(0, 1) != 0)
			return CH_START;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_END);
		return c;
	endfunction

	function automatic logic [7:0] known_type();
		case ($urandom_range(0, 4))
			0: return CH_DATA;
			1: return CH_HEADER;
			2: return CH_EOF;
			3: return CH_ACK;
			default: return CH_NACK;
		endcase
	endfunction

	task automatic random_body(input int unsigned n);
		repeat (n)
			frame_body.push_back(8'($urandom_range(0, 255)));
	endtask

	// Send one frame with the body held in frame_body and a valid length
	task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] term);
		int unsigned n;
		n = frame_body.size();
		push_byte(CH_START);
		push_byte(ftype);
		push_byte(hex_char(n[7:4]));
		push_byte(hex_char(n[3:0]));
		foreach (frame_body[i])
			push_byte(frame_body[i]);
		push_byte(term);
		frame_body.delete();
	endtask

	task automatic queue_header(input longint unsigned total);
		longint unsigned v;
		v = total;
		do begin
			frame_body.push_front(8'(64'(CH_ZERO) + v % 10));
			v = v / 10;
		end while (v != 0);
		queue_frame(CH_HEADER, CH_END);
	endtask

	// Header, data frames and EOF, mostly consistent
	task automatic queue_message();
		int unsigned lens[4];
		int unsigned n_data;
		longint unsigned sum;
		n_data = $urandom_range(1, 4);
		sum = 0;
		for (int i = 0; i < n_data; i++) begin
			lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			sum += lens[i];
		end
		if ($urandom_range(0, 6) == 0)
			sum += $urandom_range(1, 3);
		// sometimes skip the header so the count carries over from the last message
		if ($urandom_range(0, 9) != 0)
			queue_header(sum);
		for (int i = 0; i < n_data; i++) begin
			random_body(lens[i]);
			queue_frame(CH_DATA, ($urandom_range(0, 11) == 0) ? bad_term() : CH_END);
		end
		if ($urandom_range(0, 7) == 0)
			random_body($urandom_range(1, 3));
		queue_frame(CH_EOF, ($urandom_range(0, 15) == 0) ? bad_term() : CH_END);
	endtask

	task automatic queue_bad_length();
		int unsigned mode;
		logic [7:0] hi;
		logic [7:0] lo;
		mode = $urandom_range(0, 2);
		hi = (mode == 1) ? hex_char(4'($urandom_range(0, 15))) : non_hex_char();
		lo = (mode == 0) ? hex_char(4'($urandom_range(0, 15))) : non_hex_char();
		push_byte(CH_START);
		push_byte(known_type());
		push_byte(hi);
		push_byte(lo);
		push_byte(($urandom_range(0, 7) == 0) ? bad_term() : CH_END);
	endtask

	task automatic queue_unknown_frame();
		logic [7:0] t;
		do
			t = 8'($urandom_range(0, 255));
		while (t inside {CH_DATA, CH_HEADER, CH_EOF, CH_ACK, CH_NACK});
		random_body($urandom_range(0, 6));
		queue_frame(t, ($urandom_range(0, 3) == 0) ? bad_term() : CH_END);
	endtask

	task automatic queue_odd_header();
		int unsigned n;
		int unsigned at;
		case ($urandom_range(0, 5))
			0: begin
				// digits with one non-digit somewhere
				n = $urandom_range(1, 6);
				at = $urandom_range(0, n);
				for (int i = 0; i <= n; i++) begin
					if (i == at)
						frame_body.push_back(($urandom_range(0, 1) != 0) ? 8'h2F :
							(($urandom_range(0, 1) != 0) ? 8'h3A : 8'($urandom_range(0, 255))));
					else
						frame_body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				queue_frame(CH_HEADER, CH_END);
			end
			1: queue_header(64'hFFFF_FFFF + 64'($urandom_range(0, 2)));
			2: begin
				repeat (20)
					frame_body.push_back(CH_NINE);
				queue_frame(CH_HEADER, CH_END);
			end
			3: queue_frame(CH_HEADER, CH_END);
			4: begin
				repeat ($urandom_range(1, 12))
					frame_body.push_back(CH_ZERO);
				queue_header($urandom_range(0, 99));
			end
			default: begin
				random_body($urandom_range(0, 3));
				queue_frame(CH_HEADER, bad_term());
			end
		endcase
	endtask

	// ---------------- sender ----------------

	// Offer the next byte once the current one is taken; gaps follow each item
	always @(negedge clk) begin
		rx_slot_t slot;
		if (arst_n && (!rx_valid || rx_taken)) begin
			rx_taken = 1'b0;
			if ($urandom_range(0, 63) == 0)
				src_calm = !src_calm;
			if (src_gap > 0) begin
				src_gap--;
				rx_valid <= 1'b0;
			end else if (rx_stream.size() != 0 && !rx_stream[0].drain) begin
				slot = rx_stream.pop_front();
				rx_byte <= slot.data;
				rx_valid <= 1'b1;
				src_gap = idle_len(src_calm);
			end else begin
				// hold at a drain slot until all due items are out
				if (rx_stream.size() != 0 && link_results_due.size() == 0)
					void'(rx_stream.pop_front());
				rx_valid <= 1'b0;
			end
		end
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0)
				sink_calm = !sink_calm;
			if (hold_off) begin
				res_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				sink_gap = idle_len(sink_calm);
			end
		end
	end

	// Hold off the output for long stretches while the sender keeps going
	initial begin
		while (bytes_taken < 150)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (60)
			@(posedge clk);
		hold_off = 1'b0;
		while (bytes_taken < 250)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (45)
			@(posedge clk);
		hold_off = 1'b0;
	end

	// ---------------- monitor ----------------

	// Check each output item against the oldest due one, then predict from the input side
	always @(posedge clk) begin
		link_result_t due;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (link_results_due.size() == 0) begin
					note_failure($sformatf("unexpected item: kind %0d byte %02h len %0d last %0b",
						out_kind, out_byte, message_length, last_of_run));
				end else begin
					due = link_results_due.pop_front();
					if (out_kind !== due.kind)
						note_failure($sformatf("out_kind %0d, expected %s", out_kind,
							due.kind.name()));
					if (out_byte !== due.data)
						note_failure($sformatf("out_byte %02h, expected %02h", out_byte,
							due.data));
					if (message_length !== due.len)
						note_failure($sformatf("message_length %0d, expected %0d",
							message_length, due.len));
					if (last_of_run !== due.last)
						note_failure($sformatf("last_of_run %0b, expected %0b", last_of_run,
							due.last));
				end
			end
			if (rx_valid && rx_ready) begin
				predict_link_byte(rx_byte);
				rx_taken = 1'b1;
				bytes_taken++;
			end
		end
	end

	// ---------------- stimulus and end of run ----------------

	initial begin
		int unsigned pick;
		int unsigned stop_at;
		logic [7:0] noise;

		// idle noise, then a header, data and EOF exchange that completes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_END);
		queue_text("*~013#");
		queue_text("*>03");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		push_byte(CH_END);
		queue_text("*@00#");
		// peer ack and nack
		queue_text("*<00#*?00#");
		// bad length digits give an empty data frame
		queue_text("*>G1#*>1g#");
		// bad terminator after payload went out
		queue_text("*>02abX");
		// non-digit header clears the total, then the EOF is corrupt
		queue_text("*~021x#*>01q#*@00#");
		// one past the largest total, then the largest total
		queue_text("*~0A4294967296#*~0A4294967295#*@00#");
		// empty header, EOF completes on zero
		queue_text("*~00#*@00#");
		// unknown type stays silent; a bad terminator on it still drops
		queue_text("*Z02ab#*Z00*");
		// longer data frame, body bytes spread over the whole byte range
		queue_text("*>3f");
		for (int i = 0; i < 63; i++)
			push_byte(8'(i * 4 + 3));
		push_byte(CH_END);
		queue_text("*@00#");
		push_drain();

		// random frames, mostly well-formed messages
		stop_at = 310;
		while (stream_len < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_message();
			end else if (pick < 65) begin
				if ($urandom_range(0, 4) == 0)
					random_body($urandom_range(1, 2));
				queue_frame(($urandom_range(0, 1) != 0) ? CH_ACK : CH_NACK,
					($urandom_range(0, 9) == 0) ? bad_term() : CH_END);
			end else if (pick < 72) begin
				// idle noise, never a start byte
				repeat ($urandom_range(1, 4)) begin
					do
						noise = 8'($urandom_range(0, 255));
					while (noise == CH_START);
					push_byte(noise);
				end
			end else if (pick < 80) begin
				queue_bad_length();
			end else if (pick < 88) begin
				queue_unknown_frame();
			end else begin
				queue_odd_header();
			end
			if ($urandom_range(0, 24) == 0)
				push_drain();
		end

		// reset
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for all bytes to go in and all due items to come out
		while (rx_stream.size() != 0 || rx_valid)
			@(posedge clk);
		while (link_results_due.size() != 0)
			@(posedge clk);
		repeat (30)
			@(posedge clk);

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
